### src/quaternion_arithmetic_unit_assert.svh
// assertion macros shared by the quaternion arithmetic unit
`ifndef QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
`define QUATERNION_ARITHMETIC_UNIT_ASSERT_SVH
// condition in the same cycle
`define QAU_ASSERT_NOW(label, cond_a, cond_b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond_a) |-> (cond_b)) \
	else $error("qau check failed");
// condition in the next cycle
`define QAU_ASSERT_NEXT(label, cond_a, cond_b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond_a) |=> (cond_b)) \
	else $error("qau check failed");
`endif

### src/qau_pkg.sv
// types and constants of the quaternion arithmetic unit
`default_nettype none
package qau_pkg;
	localparam int DATA_W    = 32;
	localparam int QUO_W     = 32;
	localparam int ROOT_W    = 32;
	localparam int RAD_W     = 64;
	localparam int SQ_W      = 65;
	localparam int FRONT_LAT = 3;
	localparam int SQRT_LAT  = ROOT_W;
	localparam int DIV_LAT   = QUO_W + 1;

	localparam logic [DATA_W-1:0] POS_MAX = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] NEG_MAX = 32'h8000_0000;

	typedef enum logic [2:0] {
		ACT_ADD       = 3'd0,
		ACT_SUB       = 3'd1,
		ACT_MUL       = 3'd2,
		ACT_SCALE     = 3'd3,
		ACT_CONJ      = 3'd4,
		ACT_NORM      = 3'd5,
		ACT_NORMALIZE = 3'd6,
		ACT_INV       = 3'd7
	} action_t;

	// element 0 is the real part, then i, j, k
	typedef logic [3:0][DATA_W-1:0] quat_t;

	typedef struct packed {
		action_t act;
		logic    sat;
		logic    degen;
	} ctl_t;
endpackage
`default_nettype wire

### src/qau_delay.sv
// shift line that keeps side data in step with the pipeline
`default_nettype none
module qau_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	logic [WIDTH-1:0] sr_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int k = 1; k < DEPTH; k++) sr_q[k] <= sr_q[k-1];
		end
	end

	assign q = sr_q[DEPTH-1];
endmodule
`default_nettype wire

### src/qau_front.sv
// front stages: products, sums, rounding, clipping and squared norm
`default_nettype none
module qau_front #(
	parameter int FRAC_BITS = 24
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [31:0]           thr,
	input  qau_pkg::action_t      act,
	input  qau_pkg::quat_t        a,
	input  qau_pkg::quat_t        b,
	input  logic [31:0]           s,
	output qau_pkg::ctl_t         ctl,
	output qau_pkg::quat_t        a_o,
	output qau_pkg::quat_t        abs_o,
	output qau_pkg::quat_t        r_o,
	output logic [64:0]           sq_o,
	output logic [64-FRAC_BITS:0] sqq_o
);
	import qau_pkg::*;

	localparam int SQW = SQ_W - FRAC_BITS;
	localparam logic [65:0] RND = 66'd1 << (FRAC_BITS - 1);

	// {clipped, value}
	function automatic logic [32:0] clip_33(input logic [32:0] v);
		if (v[32] != v[31]) return {1'b1, v[32] ? NEG_MAX : POS_MAX};
		return {1'b0, v[31:0]};
	endfunction

	function automatic logic [32:0] clip_66(input logic [65:0] v);
		if (v[65:31] != {35{v[65]}}) return {1'b1, v[65] ? NEG_MAX : POS_MAX};
		return {1'b0, v[31:0]};
	endfunction

	function automatic logic [65:0] ext(input logic [63:0] p);
		return {{2{p[63]}}, p};
	endfunction

	// stage 1
	logic [31:0]        bsel [4];
	logic [32:0]        fast_c [4];
	logic signed [63:0] prod_s1 [4][4];
	logic [63:0]        sqp_s1 [4];
	quat_t              a_s1, fast_s1;
	logic               fsat_s1;
	action_t            act_s1;

	always_comb begin
		for (int j = 0; j < 4; j++) bsel[j] = b[j];
		// scale reuses the lanes that multiply by the real part of b
		if (act == ACT_SCALE) bsel[0] = s;
		for (int i = 0; i < 4; i++) begin
			case (act)
				ACT_ADD:  fast_c[i] = clip_33({a[i][31], a[i]} + {b[i][31], b[i]});
				ACT_SUB:  fast_c[i] = clip_33({a[i][31], a[i]} - {b[i][31], b[i]});
				ACT_CONJ: fast_c[i] = (i == 0) ? {1'b0, a[i]} :
					clip_33(33'd0 - {a[i][31], a[i]});
				default:  fast_c[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) prod_s1[i][j] <= $signed(a[i]) * $signed(bsel[j]);
				sqp_s1[i]  <= $signed(a[i]) * $signed(a[i]);
				fast_s1[i] <= fast_c[i][31:0];
			end
			fsat_s1 <= fast_c[0][32] | fast_c[1][32] | fast_c[2][32] | fast_c[3][32];
			act_s1  <= act;
			a_s1    <= a;
		end
	end

	// stage 2
	logic [65:0] wsum_c [4];
	logic [65:0] wsum_s2 [4];
	logic [64:0] sq_s2;
	quat_t       a_s2, fast_s2;
	logic        fsat_s2;
	action_t     act_s2;

	always_comb begin
		if (act_s1 == ACT_SCALE) begin
			for (int i = 0; i < 4; i++) wsum_c[i] = ext(prod_s1[i][0]) + RND;
		end else begin
			wsum_c[0] = ext(prod_s1[0][0]) - ext(prod_s1[1][1]) - ext(prod_s1[2][2])
				- ext(prod_s1[3][3]) + RND;
			wsum_c[1] = ext(prod_s1[1][0]) + ext(prod_s1[0][1]) + ext(prod_s1[2][3])
				- ext(prod_s1[3][2]) + RND;
			wsum_c[2] = ext(prod_s1[0][2]) - ext(prod_s1[1][3]) + ext(prod_s1[2][0])
				+ ext(prod_s1[3][1]) + RND;
			wsum_c[3] = ext(prod_s1[0][3]) + ext(prod_s1[1][2]) - ext(prod_s1[2][1])
				+ ext(prod_s1[3][0]) + RND;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) wsum_s2[i] <= wsum_c[i];
			sq_s2   <= {1'b0, sqp_s1[0]} + {1'b0, sqp_s1[1]} + {1'b0, sqp_s1[2]}
				+ {1'b0, sqp_s1[3]};
			fast_s2 <= fast_s1;
			fsat_s2 <= fsat_s1;
			act_s2  <= act_s1;
			a_s2    <= a_s1;
		end
	end

	// stage 3
	logic [65:0]    sh [4];
	logic [32:0]    prod_c [4];
	logic [SQW-1:0] sqq_c;
	logic           degen_c;
	logic           mul_c;
	ctl_t           ctl_s3;
	quat_t          a_s3, abs_s3, r_s3;
	logic [64:0]    sq_s3;
	logic [SQW-1:0] sqq_s3;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			sh[i]     = $signed(wsum_s2[i]) >>> FRAC_BITS;
			prod_c[i] = clip_66(sh[i]);
		end
		sqq_c   = sq_s2[SQ_W-1:FRAC_BITS];
		degen_c = sqq_c < SQW'(thr);
		mul_c   = (act_s2 == ACT_MUL) || (act_s2 == ACT_SCALE);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				r_s3[i]   <= mul_c ? prod_c[i][31:0] : fast_s2[i];
				abs_s3[i] <= a_s2[i][31] ? 32'd0 - a_s2[i] : a_s2[i];
			end
			ctl_s3.act   <= act_s2;
			ctl_s3.sat   <= mul_c ? (prod_c[0][32] | prod_c[1][32] | prod_c[2][32]
				| prod_c[3][32]) : fsat_s2;
			ctl_s3.degen <= degen_c;
			a_s3   <= a_s2;
			sq_s3  <= sq_s2;
			sqq_s3 <= sqq_c;
		end
	end

	assign ctl   = ctl_s3;
	assign a_o   = a_s3;
	assign abs_o = abs_s3;
	assign r_o   = r_s3;
	assign sq_o  = sq_s3;
	assign sqq_o = sqq_s3;
endmodule
`default_nettype wire

### src/qau_isqrt.sv
// pipelined integer square root, one result bit per stage
`default_nettype none
module qau_isqrt (
	input  logic                         clk,
	input  logic                         en,
	input  logic [qau_pkg::RAD_W-1:0]    rad,
	output logic [qau_pkg::ROOT_W-1:0]   root
);
	import qau_pkg::*;

	logic [ROOT_W+1:0] rem_s  [ROOT_W-1];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [RAD_W-1:0]  rad_s  [ROOT_W-1];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [ROOT_W+1:0] rem_in, shifted, trial;
		logic [ROOT_W-1:0] root_in;
		logic [RAD_W-1:0]  rad_in;
		logic              ge;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
		end

		always_comb begin
			// bring down the next two radicand bits and try root*4+1
			shifted = {rem_in[ROOT_W-1:0], rad_in[RAD_W-1 -: 2]};
			trial   = {root_in, 2'b01};
			ge      = shifted >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) root_s[k] <= {root_in[ROOT_W-2:0], ge};
		end

		if (k < ROOT_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? shifted - trial : shifted;
					rad_s[k] <= {rad_in[RAD_W-3:0], 2'b00};
				end
			end
		end
	end

	assign root = root_s[ROOT_W-1];
endmodule
`default_nettype wire

### src/qau_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module qau_div #(
	parameter int NUM_W = 57,
	parameter int DEN_W = 41
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [NUM_W-1:0]           num,
	input  logic [DEN_W-1:0]           den,
	output logic [qau_pkg::QUO_W-1:0]  quo,
	output logic                       ovf
);
	import qau_pkg::*;

	logic [DEN_W-1:0] rem_s [QUO_W];
	logic [QUO_W-1:0] lo_s  [QUO_W];
	logic [DEN_W-1:0] den_s [QUO_W];
	logic [QUO_W-1:0] q_s   [QUO_W];
	logic             ovf_s [QUO_W+1];
	logic             ovf_c;

	// quotient would not fit in the result bits
	assign ovf_c = (num >> QUO_W) >= NUM_W'(den);

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= ovf_c;
			rem_s[0] <= ovf_c ? '0 : DEN_W'(num >> QUO_W);
			lo_s[0]  <= num[QUO_W-1:0];
			den_s[0] <= den;
		end
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_step
		logic [DEN_W:0]   shifted, diff;
		logic             ge;
		logic [QUO_W-1:0] q_in;

		if (k == 1) begin : g_first
			assign q_in = '0;
		end else begin : g_next
			assign q_in = q_s[k-2];
		end

		always_comb begin
			shifted = {rem_s[k-1], lo_s[k-1][QUO_W-1]};
			diff    = shifted - {1'b0, den_s[k-1]};
			ge      = shifted >= {1'b0, den_s[k-1]};
		end

		always_ff @(posedge clk) begin
			if (en) begin
				q_s[k-1] <= {q_in[QUO_W-2:0], ge};
				ovf_s[k] <= ovf_s[k-1];
			end
		end

		if (k < QUO_W) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
					lo_s[k]  <= {lo_s[k-1][QUO_W-2:0], 1'b0};
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	assign quo = q_s[QUO_W-1];
	assign ovf = ovf_s[QUO_W];
endmodule
`default_nettype wire

### src/quaternion_arithmetic_unit.sv
// an accepted input word passes the front stages, square root, divisor select register, divider and result register
// throughput: one word per cycle; the whole pipeline holds while a result waits
// depth is set by the 32-stage square root followed by the 33-stage divider
// reset clears the valid bits and sets the zero-norm threshold to 1
// the threshold write port is always ready
`default_nettype none
`include "quaternion_arithmetic_unit_assert.svh"
module quaternion_arithmetic_unit #(
	parameter int FRAC_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  action,
	input  logic [31:0] a_w,
	input  logic [31:0] a_x,
	input  logic [31:0] a_y,
	input  logic [31:0] a_z,
	input  logic [31:0] b_w,
	input  logic [31:0] b_x,
	input  logic [31:0] b_y,
	input  logic [31:0] b_z,
	input  logic [31:0] scale_factor,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] r_w,
	output logic [31:0] r_x,
	output logic [31:0] r_y,
	output logic [31:0] r_z,
	output logic [30:0] magnitude,
	output logic        saturated,
	output logic        degenerate,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);
	import qau_pkg::*;

	localparam int SQW = SQ_W - FRAC_BITS;
	localparam int DW  = (SQW > 33) ? SQW : 33;
	localparam int NW  = (((32 + FRAC_BITS) > (DW - 1)) ? (32 + FRAC_BITS) : (DW - 1)) + 1;
	localparam int LAT = FRONT_LAT + SQRT_LAT + 1 + DIV_LAT + 1;
	localparam logic [DATA_W-1:0] IDENT = 32'd1 << FRAC_BITS;

	typedef struct packed {
		ctl_t           ctl;
		quat_t          a;
		quat_t          absa;
		quat_t          r;
		logic [SQW-1:0] sqq;
		logic           sq_ovf;
	} d1_t;

	typedef struct packed {
		ctl_t        ctl;
		quat_t       a;
		quat_t       r;
		logic [3:0]  neg;
		logic        spec;
		logic        big;
		logic [30:0] mag;
	} d2_t;

	logic [31:0]    thr_q;
	logic [LAT-1:0] vld_q;
	logic           adv;

	assign adv       = !vld_q[LAT-1] || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= 32'd1;
			vld_q <= '0;
		end else begin
			if (cfg_valid) thr_q <= cfg_data;
			if (adv) vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	// front stages
	quat_t          a_in, b_in;
	ctl_t           f_ctl;
	quat_t          f_a, f_abs, f_r;
	logic [64:0]    f_sq;
	logic [SQW-1:0] f_sqq;

	assign a_in = {a_z, a_y, a_x, a_w};
	assign b_in = {b_z, b_y, b_x, b_w};

	qau_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk   (clk),
		.en    (adv),
		.thr   (thr_q),
		.act   (action_t'(action)),
		.a     (a_in),
		.b     (b_in),
		.s     (scale_factor),
		.ctl   (f_ctl),
		.a_o   (f_a),
		.abs_o (f_abs),
		.r_o   (f_r),
		.sq_o  (f_sq),
		.sqq_o (f_sqq)
	);

	// square root with its side data
	logic [ROOT_W-1:0] root;
	d1_t               d1_in, d1_out;

	qau_isqrt u_isqrt (
		.clk  (clk),
		.en   (adv),
		.rad  (f_sq[RAD_W-1:0]),
		.root (root)
	);

	always_comb begin
		d1_in.ctl    = f_ctl;
		d1_in.a      = f_a;
		d1_in.absa   = f_abs;
		d1_in.r      = f_r;
		d1_in.sqq    = f_sqq;
		d1_in.sq_ovf = f_sq[SQ_W-1];
	end

	qau_delay #(.WIDTH($bits(d1_t)), .DEPTH(SQRT_LAT)) u_dly_root (
		.clk (clk),
		.en  (adv),
		.d   (d1_in),
		.q   (d1_out)
	);

	// divisor select and dividend
	logic [32:0]    n_c;
	logic           big_c, spec_c;
	logic [30:0]    mag_c;
	logic [DW-1:0]  den_c;
	logic [3:0]     neg_c;
	logic [NW-1:0]  num_c [4];
	logic [NW-1:0]  num_s4 [4];
	logic [DW-1:0]  den_s4;
	d2_t            d2_in, d2_out;
	d2_t            d2_s4;

	always_comb begin
		// a squared norm of 2^64 or more has root 2^32
		n_c   = d1_out.sq_ovf ? {1'b1, 32'd0} : {1'b0, root};
		big_c = n_c[32] | n_c[31];
		mag_c = big_c ? POS_MAX[30:0] : n_c[30:0];
		den_c = (d1_out.ctl.act == ACT_INV) ? DW'(d1_out.sqq) : DW'(n_c);
		case (d1_out.ctl.act)
			ACT_NORMALIZE: spec_c = d1_out.ctl.degen || (n_c == '0);
			ACT_INV:       spec_c = d1_out.ctl.degen || (d1_out.sqq == '0);
			default:       spec_c = 1'b0;
		endcase
		for (int i = 0; i < 4; i++) begin
			if (d1_out.ctl.act == ACT_INV && i != 0)
				neg_c[i] = !d1_out.a[i][31] && (d1_out.a[i] != '0);
			else
				neg_c[i] = d1_out.a[i][31];
			// half the divisor added for rounding to nearest
			num_c[i] = (NW'(d1_out.absa[i]) << FRAC_BITS) + NW'(den_c[DW-1:1]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) num_s4[i] <= num_c[i];
			den_s4      <= den_c;
			d2_s4.ctl   <= d1_out.ctl;
			d2_s4.a     <= d1_out.a;
			d2_s4.r     <= d1_out.r;
			d2_s4.neg   <= neg_c;
			d2_s4.spec  <= spec_c;
			d2_s4.big   <= big_c;
			d2_s4.mag   <= mag_c;
		end
	end

	assign d2_in = d2_s4;

	logic [QUO_W-1:0] quo [4];
	logic             qovf [4];

	for (genvar i = 0; i < 4; i++) begin : g_lane
		qau_div #(.NUM_W(NW), .DEN_W(DW)) u_div (
			.clk (clk),
			.en  (adv),
			.num (num_s4[i]),
			.den (den_s4),
			.quo (quo[i]),
			.ovf (qovf[i])
		);
	end

	qau_delay #(.WIDTH($bits(d2_t)), .DEPTH(DIV_LAT)) u_dly_div (
		.clk (clk),
		.en  (adv),
		.d   (d2_in),
		.q   (d2_out)
	);

	// result select
	quat_t       qr_c, r_c;
	logic [3:0]  qsat_c;
	logic        sat_c;
	quat_t       r_s5;
	logic [30:0] mag_s5;
	logic        sat_s5, degen_s5;
	action_t     act_s5;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			if (!d2_out.neg[i]) begin
				qsat_c[i] = qovf[i] || quo[i][31];
				qr_c[i]   = qsat_c[i] ? POS_MAX : quo[i];
			end else begin
				qsat_c[i] = qovf[i] || (quo[i][31] && (quo[i][30:0] != '0));
				qr_c[i]   = qsat_c[i] ? NEG_MAX : 32'd0 - quo[i];
			end
		end
		case (d2_out.ctl.act)
			ACT_NORM: begin
				r_c   = '0;
				sat_c = d2_out.big;
			end
			ACT_NORMALIZE: begin
				r_c   = d2_out.spec ? d2_out.a : qr_c;
				sat_c = !d2_out.spec && (qsat_c != '0);
			end
			ACT_INV: begin
				r_c   = d2_out.spec ? {96'd0, IDENT} : qr_c;
				sat_c = !d2_out.spec && (qsat_c != '0);
			end
			default: begin
				r_c   = d2_out.r;
				sat_c = d2_out.ctl.sat;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r_s5     <= r_c;
			mag_s5   <= d2_out.mag;
			sat_s5   <= sat_c;
			degen_s5 <= d2_out.ctl.degen;
			act_s5   <= d2_out.ctl.act;
		end
	end

	assign r_w        = r_s5[0];
	assign r_x        = r_s5[1];
	assign r_y        = r_s5[2];
	assign r_z        = r_s5[3];
	assign magnitude  = mag_s5;
	assign saturated  = sat_s5;
	assign degenerate = degen_s5;

	`QAU_ASSERT_NOW(a_norm_zero, out_valid && act_s5 == ACT_NORM, r_w == '0 && r_x == '0 && r_y == '0 && r_z == '0)
	`QAU_ASSERT_NOW(a_inv_identity, out_valid && act_s5 == ACT_INV && degenerate, r_w == IDENT && r_x == '0 && r_y == '0 && r_z == '0)
	`QAU_ASSERT_NOW(a_unit_pass, out_valid && act_s5 == ACT_NORMALIZE && degenerate, !saturated)
	`QAU_ASSERT_NEXT(a_word_enters, in_valid && in_ready, vld_q[0])
	`QAU_ASSERT_NEXT(a_stall_holds, !adv, $stable(vld_q))
endmodule
`default_nettype wire
